// ===== hw/rtl/sab_pkg.sv =====
// Shared constants, types and helpers for the suffix automaton builder.
package sab_pkg;

	localparam int MAX_STATES = 2048;
	localparam int ALPHABET   = 26;
	localparam int SW         = $clog2(MAX_STATES);
	localparam int UW         = SW + 1;
	localparam int LW         = 5;
	localparam int TR_DEPTH   = MAX_STATES * ALPHABET;
	localparam int TRW        = $clog2(TR_DEPTH);
	localparam int NST        = 33;

	typedef logic [SW-1:0]  sid_t;
	typedef logic [UW-1:0]  cnt_t;
	typedef logic [TRW-1:0] tra_t;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_COUNT  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;

	localparam sid_t COUNT_MAX = {SW{1'b1}};

	typedef enum logic [NST-1:0] {
		ST_INIT  = NST'(1) << 0,
		ST_IDLE  = NST'(1) << 1,
		ST_T1    = NST'(1) << 2,
		ST_T1W   = NST'(1) << 3,
		ST_Q     = NST'(1) << 4,
		ST_QW    = NST'(1) << 5,
		ST_CL1   = NST'(1) << 6,
		ST_CL1W  = NST'(1) << 7,
		ST_CL2   = NST'(1) << 8,
		ST_CL3   = NST'(1) << 9,
		ST_CPR   = NST'(1) << 10,
		ST_CPW   = NST'(1) << 11,
		ST_T2    = NST'(1) << 12,
		ST_T2W   = NST'(1) << 13,
		ST_CCLR  = NST'(1) << 14,
		ST_HR    = NST'(1) << 15,
		ST_HW    = NST'(1) << 16,
		ST_HB    = NST'(1) << 17,
		ST_HU    = NST'(1) << 18,
		ST_PR    = NST'(1) << 19,
		ST_PW    = NST'(1) << 20,
		ST_DR    = NST'(1) << 21,
		ST_DL    = NST'(1) << 22,
		ST_DB    = NST'(1) << 23,
		ST_DW    = NST'(1) << 24,
		ST_AR    = NST'(1) << 25,
		ST_AS    = NST'(1) << 26,
		ST_AS2   = NST'(1) << 27,
		ST_AT    = NST'(1) << 28,
		ST_AT2   = NST'(1) << 29,
		ST_AW    = NST'(1) << 30,
		ST_RR    = NST'(1) << 31,
		ST_RW    = NST'(1) << 32
	} state_t;

	function automatic tra_t tr_addr(sid_t s, logic [LW-1:0] c);
		tra_t base;
		base = TRW'(s) * TRW'(ALPHABET);
		return base + TRW'(c);
	endfunction

	function automatic sid_t sat_add(sid_t a, sid_t b);
		logic [SW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[SW] ? COUNT_MAX : sum[SW-1:0];
	endfunction

endpackage

// ===== hw/rtl/suffix_automaton_builder.sv =====
// Suffix automaton builder: top level with sequencer and state memories.
// Usage:
//   One request channel (req_valid/req_stall, fields mode, letter, state_index)
//   and one response channel (rsp_valid/rsp_stall, fields status, state_id,
//   link_id, length, occurrences, cloned). Every request gives one response.
//   After reset the block sweeps the transition memory to zero, one entry a
//   cycle over MAX_STATES*ALPHABET = 53248 entries, during which req_stall is high.
//   The block works on one request at a time; req_stall is low only while
//   the sequencer is idle and the response register is free or being taken.
//   All access goes through one shared RAM read port per memory, by state:
//   - read: RR then RW; a rejected request is answered from the idle state.
//   - append: T1 and T1W per suffix-link step of the first walk, Q and QW for
//     the target check, and on a clone CL1, CL1W, CL2, CL3, a CPR/CPW pair per
//     letter and a T2/T2W pair per redirect step and for the step that ends it.
//     The next request can be taken in the cycle the response appears, if not stalled.
//   - count: CCLR clears 2048 buckets, then HR..HU per non-root state (histogram),
//     PR/PW per bucket (prefix sums), DR..DW (placement), AR..AW (accumulation).
//   A stalled response holds in the output register; the next request waits.
module suffix_automaton_builder
	import sab_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    mode,
	input  logic [LW-1:0] letter,
	input  logic [SW-1:0] state_index,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic [1:0]    status,
	output logic [SW-1:0] state_id,
	output logic [SW-1:0] link_id,
	output logic [SW-1:0] length,
	output logic [SW-1:0] occurrences,
	output logic          cloned
);

	state_t        state_q;
	cnt_t          used_q;
	sid_t          last_q;
	sid_t          p_q, cur_q, q_q, cl_q, curlen_q, lenp_q, idx_q;
	sid_t          lq_q, s_q, t_q, cs_q, run_q;
	logic [LW-1:0] c_q, j_q;
	logic          first_q;
	cnt_t          i_q, k_q;
	logic [TRW:0]  init_q;

	// memory ports
	logic tr_we, lk_we, ln_we, ct_we, bk_we, bl_we;
	tra_t tr_wa, tr_ra;
	sid_t tr_wd, tr_rd;
	sid_t lk_wa, lk_wd, lk_ra, lk_rd;
	sid_t ln_wa, ln_wd, ln_ra, ln_rd;
	sid_t ct_wa, ct_wd, ct_ra, ct_rd;
	sid_t bk_wa, bk_wd, bk_ra, bk_rd;
	sid_t bl_wa, bl_wd, bl_ra, bl_rd;

	logic req_acc, rsp_acc, init_low;

	assign req_stall = (state_q != ST_IDLE) || (rsp_valid && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_acc   = rsp_valid && !rsp_stall;
	assign init_low  = init_q < (TRW+1)'(MAX_STATES);

	sab_ram #(.WIDTH(SW), .DEPTH(TR_DEPTH)) u_trans (
		.clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd));
	sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
	sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_len (
		.clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
	sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_cnt (
		.clk(clk), .we(ct_we), .waddr(ct_wa), .wdata(ct_wd), .raddr(ct_ra), .rdata(ct_rd));
	sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));
	sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_bylen (
		.clk(clk), .we(bl_we), .waddr(bl_wa), .wdata(bl_wd), .raddr(bl_ra), .rdata(bl_rd));

	// Memory port steering: each state issues at most one read per memory,
	// consumed by the following state.
	always_comb begin
		tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = tr_addr(p_q, c_q);
		lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = p_q;
		ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = p_q;
		ct_we = 1'b0; ct_wa = '0; ct_wd = '0; ct_ra = idx_q;
		bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = lq_q;
		bl_we = 1'b0; bl_wa = '0; bl_wd = '0;
		bl_ra = SW'(k_q - cnt_t'(1));
		unique case (state_q)
			ST_INIT: begin
				tr_we = 1'b1;
				tr_wa = init_q[TRW-1:0];
				lk_we = init_low; lk_wa = init_q[SW-1:0];
				ln_we = init_low; ln_wa = init_q[SW-1:0];
				ct_we = init_low; ct_wa = init_q[SW-1:0];
			end
			ST_T1W: begin
				tr_wa = tr_addr(p_q, c_q);
				tr_wd = cur_q;
				tr_we = (tr_rd == '0);
				ln_we = first_q; ln_wa = cur_q; ln_wd = ln_rd + sid_t'(1);
				ct_we = first_q; ct_wa = cur_q; ct_wd = sid_t'(1);
			end
			ST_Q: ln_ra = q_q;
			ST_QW: begin
				if (q_q == cur_q || ln_rd == lenp_q + sid_t'(1)) begin
					lk_we = 1'b1;
					lk_wa = cur_q;
					lk_wd = (q_q == cur_q) ? '0 : q_q;
				end else begin
					ln_we = 1'b1; ln_wa = used_q[SW-1:0]; ln_wd = lenp_q + sid_t'(1);
					ct_we = 1'b1; ct_wa = used_q[SW-1:0]; ct_wd = '0;
				end
			end
			ST_CL1: lk_ra = q_q;
			ST_CL1W: begin
				lk_we = 1'b1; lk_wa = cl_q; lk_wd = lk_rd;
			end
			ST_CL2: begin
				lk_we = 1'b1; lk_wa = cur_q; lk_wd = cl_q;
			end
			ST_CL3: begin
				lk_we = 1'b1; lk_wa = q_q; lk_wd = cl_q;
			end
			ST_CPR: tr_ra = tr_addr(q_q, j_q);
			ST_CPW: begin
				tr_we = 1'b1; tr_wa = tr_addr(cl_q, j_q); tr_wd = tr_rd;
			end
			ST_T2W: begin
				tr_we = (tr_rd == q_q); tr_wa = tr_addr(p_q, c_q); tr_wd = cl_q;
			end
			ST_CCLR: begin
				bk_we = 1'b1; bk_wa = k_q[SW-1:0];
			end
			ST_HR: ln_ra = i_q[SW-1:0];
			ST_HU: begin
				bk_we = 1'b1; bk_wa = lq_q; bk_wd = bk_rd + sid_t'(1);
			end
			ST_PR: bk_ra = k_q[SW-1:0];
			ST_PW: begin
				bk_we = 1'b1; bk_wa = k_q[SW-1:0]; bk_wd = run_q + bk_rd;
			end
			ST_DR: ln_ra = i_q[SW-1:0];
			ST_DW: begin
				bk_we = 1'b1; bk_wa = lq_q; bk_wd = bk_rd - sid_t'(1);
				bl_we = 1'b1; bl_wa = bk_rd - sid_t'(1); bl_wd = i_q[SW-1:0];
			end
			ST_AS2: begin
				lk_ra = s_q; ct_ra = s_q;
			end
			ST_AT2: ct_ra = t_q;
			ST_AW: begin
				ct_we = 1'b1; ct_wa = t_q; ct_wd = sat_add(ct_rd, cs_q);
			end
			ST_RR: begin
				lk_ra = idx_q; ln_ra = idx_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			used_q <= cnt_t'(1);
			last_q <= '0;
			init_q <= '0;
			rsp_valid <= 1'b0;
			status <= STATUS_OK; state_id <= '0; link_id <= '0;
			length <= '0; occurrences <= '0; cloned <= 1'b0;
			p_q <= '0; cur_q <= '0; q_q <= '0; cl_q <= '0; curlen_q <= '0;
			lenp_q <= '0; idx_q <= '0; lq_q <= '0; s_q <= '0; t_q <= '0;
			cs_q <= '0; run_q <= '0; c_q <= '0; j_q <= '0; first_q <= 1'b0;
			i_q <= '0; k_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + (TRW+1)'(1);
					if (init_q == (TRW+1)'(TR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						state_id <= '0; link_id <= '0;
						length <= '0; occurrences <= '0; cloned <= 1'b0;
						unique case (mode)
							MODE_APPEND: begin
								if (32'(letter) >= ALPHABET) begin
									rsp_valid <= 1'b1;
									status <= STATUS_BAD;
								end else if (32'(used_q) + 2 > MAX_STATES) begin
									rsp_valid <= 1'b1;
									status <= STATUS_FULL;
								end else begin
									// start the first suffix-link walk
									rsp_valid <= 1'b0;
									p_q <= last_q;
									cur_q <= used_q[SW-1:0];
									last_q <= used_q[SW-1:0];
									used_q <= used_q + cnt_t'(1);
									c_q <= letter;
									first_q <= 1'b1;
									state_q <= ST_T1;
								end
							end
							MODE_COUNT: begin
								rsp_valid <= 1'b0;
								k_q <= '0;
								state_q <= ST_CCLR;
							end
							MODE_READ: begin
								if (cnt_t'(state_index) < used_q) begin
									rsp_valid <= 1'b0;
									idx_q <= state_index;
									state_q <= ST_RR;
								end else begin
									rsp_valid <= 1'b1;
									status <= STATUS_BAD;
								end
							end
							default: begin
								rsp_valid <= 1'b1;
								status <= STATUS_BAD;
							end
						endcase
					end else if (rsp_acc) begin
						rsp_valid <= 1'b0;
					end
				end
				ST_T1: state_q <= ST_T1W;
				ST_T1W: begin
					first_q <= 1'b0;
					if (first_q) begin
						curlen_q <= ln_rd + sid_t'(1);
					end
					if (tr_rd == '0) begin
						p_q <= lk_rd;
						state_q <= ST_T1;
					end else begin
						q_q <= tr_rd;
						lenp_q <= ln_rd;
						state_q <= ST_Q;
					end
				end
				ST_Q: state_q <= ST_QW;
				ST_QW: begin
					if (q_q == cur_q || ln_rd == lenp_q + sid_t'(1)) begin
						rsp_valid <= 1'b1;
						status <= STATUS_OK; state_id <= cur_q;
						link_id <= (q_q == cur_q) ? '0 : q_q;
						length <= curlen_q; occurrences <= sid_t'(1); cloned <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cl_q <= used_q[SW-1:0];
						used_q <= used_q + cnt_t'(1);
						state_q <= ST_CL1;
					end
				end
				ST_CL1: state_q <= ST_CL1W;
				ST_CL1W: state_q <= ST_CL2;
				ST_CL2: state_q <= ST_CL3;
				ST_CL3: begin
					j_q <= '0;
					state_q <= ST_CPR;
				end
				ST_CPR: state_q <= ST_CPW;
				ST_CPW: begin
					j_q <= j_q + LW'(1);
					state_q <= (32'(j_q) == ALPHABET - 1) ? ST_T2 : ST_CPR;
				end
				ST_T2: state_q <= ST_T2W;
				ST_T2W: begin
					if (tr_rd == q_q) begin
						p_q <= lk_rd;
						state_q <= ST_T2;
					end else begin
						rsp_valid <= 1'b1;
						status <= STATUS_OK; state_id <= cur_q; link_id <= cl_q;
						length <= curlen_q; occurrences <= sid_t'(1); cloned <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CCLR: begin
					k_q <= k_q + cnt_t'(1);
					if (k_q == cnt_t'(MAX_STATES - 1)) begin
						i_q <= cnt_t'(1);
						state_q <= ST_HR;
					end
				end
				ST_HR: begin
					if (i_q >= used_q) begin
						k_q <= '0;
						run_q <= '0;
						state_q <= ST_PR;
					end else begin
						state_q <= ST_HW;
					end
				end
				ST_HW: begin
					lq_q <= ln_rd;
					state_q <= ST_HB;
				end
				ST_HB: state_q <= ST_HU;
				ST_HU: begin
					i_q <= i_q + cnt_t'(1);
					state_q <= ST_HR;
				end
				ST_PR: state_q <= ST_PW;
				ST_PW: begin
					run_q <= run_q + bk_rd;
					k_q <= k_q + cnt_t'(1);
					if (k_q == cnt_t'(MAX_STATES - 1)) begin
						i_q <= used_q - cnt_t'(1);
						if (used_q == cnt_t'(1)) begin
							rsp_valid <= 1'b1;
							status <= STATUS_OK; state_id <= '0; link_id <= '0;
							length <= '0; occurrences <= '0; cloned <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DR;
						end
					end else begin
						state_q <= ST_PR;
					end
				end
				ST_DR: state_q <= ST_DL;
				ST_DL: begin
					lq_q <= ln_rd;
					state_q <= ST_DB;
				end
				ST_DB: state_q <= ST_DW;
				ST_DW: begin
					i_q <= i_q - cnt_t'(1);
					if (i_q == cnt_t'(1)) begin
						k_q <= used_q - cnt_t'(1);
						state_q <= ST_AR;
					end else begin
						state_q <= ST_DR;
					end
				end
				ST_AR: state_q <= ST_AS;
				ST_AS: begin
					s_q <= bl_rd;
					state_q <= ST_AS2;
				end
				ST_AS2: state_q <= ST_AT;
				ST_AT: begin
					t_q <= lk_rd;
					cs_q <= ct_rd;
					state_q <= ST_AT2;
				end
				ST_AT2: state_q <= ST_AW;
				ST_AW: begin
					k_q <= k_q - cnt_t'(1);
					if (k_q == cnt_t'(1)) begin
						rsp_valid <= 1'b1;
						status <= STATUS_OK; state_id <= '0; link_id <= '0;
						length <= '0; occurrences <= '0; cloned <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_AR;
					end
				end
				ST_RR: state_q <= ST_RW;
				ST_RW: begin
					rsp_valid <= 1'b1;
					status <= STATUS_OK; state_id <= idx_q; link_id <= lk_rd;
					length <= ln_rd; occurrences <= ct_rd; cloned <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> state_q == ST_IDLE)
		else $error("request taken while sequencer busy");
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_STATES)
		else $error("state count beyond capacity");
	a_last_used: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_t'(last_q) < used_q)
		else $error("last state not in use");
	a_clone_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && cloned) |-> status == STATUS_OK)
		else $error("clone flagged on a rejected request");
	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !(state_q == ST_IDLE) || rsp_valid)
		else $error("request finished without a response");

endmodule

// ===== hw/rtl/sab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
